>>> design/qbmp_pkg.sv
`default_nettype none
package qbmp_pkg;

  localparam int PIX_W     = 8;
  localparam int MEAN_W    = 8;
  localparam int LEVEL_W   = 4;
  localparam int BASE_W    = 12;
  localparam int COORD_W   = 13;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y    = 2'd2;

  localparam logic [LEVEL_W-1:0] SIDE_LOG2_RESET = 4'd10;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] corner_x;
    logic [COORD_W-1:0] corner_y;
    logic [MEAN_W-1:0]  mean;
    logic               last;
  } node_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/qbmp_in_if.sv
`default_nettype none
interface qbmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [qbmp_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

>>> design/qbmp_out_if.sv
`default_nettype none
interface qbmp_out_if;
  logic                         valid;
  logic                         ready;
  logic [qbmp_pkg::LEVEL_W-1:0] level;
  logic [qbmp_pkg::COORD_W-1:0] corner_x;
  logic [qbmp_pkg::COORD_W-1:0] corner_y;
  logic [qbmp_pkg::MEAN_W-1:0]  mean;
  logic                         last;

  modport source (output valid, output level, output corner_x, output corner_y,
                  output mean, output last, input ready);
  modport sink   (input valid, input level, input corner_x, input corner_y,
                  input mean, input last, output ready);
endinterface
`default_nettype wire

>>> design/qbmp_cell.sv
`default_nettype none
// One tree level, addressed by its span above the leaf: running sum plus one
// result slot that shifts toward the output register.
module qbmp_cell #(
  parameter int SPAN          = 1,
  parameter int MAX_SIDE_LOG2 = 10
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  qbmp_pkg::cell_ctl_t          ctl,
  input  wire  [qbmp_pkg::PIX_W-1:0]         pixel,
  input  wire  [qbmp_pkg::LEVEL_W-1:0]       side_log2,
  input  wire  [2*MAX_SIDE_LOG2-1:0]         next_idx,
  input  wire  [MAX_SIDE_LOG2-1:0]           off_x,
  input  wire  [MAX_SIDE_LOG2-1:0]           off_y,
  input  wire  [qbmp_pkg::BASE_W-1:0]        base_x,
  input  wire  [qbmp_pkg::BASE_W-1:0]        base_y,
  input  wire                                comp_up,
  output logic                               comp,
  input  wire  qbmp_pkg::node_t              node_in,
  output qbmp_pkg::node_t                    node_out
);

  localparam int SUM_W = qbmp_pkg::PIX_W + 2 * SPAN;
  localparam logic [MAX_SIDE_LOG2-1:0] CMASK = ~MAX_SIDE_LOG2'((1 << SPAN) - 1);

  logic [SUM_W-1:0] sum_r, sum_nxt, acc;
  logic             active;
  qbmp_pkg::node_t  node_r, node_nxt, fresh;

  always_comb begin
    active = (side_log2 >= qbmp_pkg::LEVEL_W'(SPAN));
    acc    = sum_r + SUM_W'(pixel);
    comp   = active && (next_idx[2*SPAN-1:0] == '0);

    fresh.valid    = comp;
    fresh.level    = side_log2 - qbmp_pkg::LEVEL_W'(SPAN);
    fresh.corner_x = qbmp_pkg::COORD_W'(base_x) + qbmp_pkg::COORD_W'(off_x & CMASK);
    fresh.corner_y = qbmp_pkg::COORD_W'(base_y) + qbmp_pkg::COORD_W'(off_y & CMASK);
    fresh.mean     = acc[2*SPAN +: qbmp_pkg::MEAN_W];
    fresh.last     = comp && !comp_up;

    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.load && active) begin
      sum_nxt = comp ? '0 : acc;
    end

    node_nxt = node_r;
    if (ctl.load) begin
      node_nxt = fresh;
    end else if (ctl.shift) begin
      node_nxt = node_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      node_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      node_r <= node_nxt;
    end
  end

  assign node_out = node_r;

endmodule
`default_nettype wire

>>> design/quadtree_block_mean_pyramid.sv
`default_nettype none
// Quadtree block-mean pyramid. Pixels of a 2^side_log2 square region enter one
// per item in quadtree order (TL, TR, BR, BL, recursively). Each pixel yields
// its leaf node, then every block it completes, bottom up, with level, corner
// and floor mean; last marks the final result of a pixel. Each level above the
// leaf is one cell holding its running sum and a result slot; slots drain one
// per cycle through the single output register while out_ch is not stalled.
// A pixel is held off until the slots of the previous pixel have drained, so
// one pixel per cycle only while pixels close no block and out_ch is ready.
// Writing side_log2 restarts the region; base_x/base_y apply to later items.
// There is no clearing pass after reset.
module quadtree_block_mean_pyramid #(
  parameter int MAX_SIDE_LOG2 = 10
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  qbmp_in_if.sink                              in_ch,
  qbmp_out_if.source                           out_ch,
  input  wire                                  cfg_we,
  input  wire  [qbmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [qbmp_pkg::CFG_W-1:0]           cfg_data
);

  localparam int IDX_W = 2 * MAX_SIDE_LOG2;

  logic [qbmp_pkg::LEVEL_W-1:0] side_r, eff_l;
  logic [qbmp_pkg::BASE_W-1:0]  base_x_r, base_y_r;
  logic [IDX_W-1:0]             idx_r, idx_nxt, idx_mask, next_idx;
  logic [MAX_SIDE_LOG2-1:0]     off_x, off_y;
  logic                         adv, accept, busy, clear;
  qbmp_pkg::cell_ctl_t          ctl;
  qbmp_pkg::node_t              out_r, out_nxt, leaf;
  qbmp_pkg::node_t              chain [MAX_SIDE_LOG2+1:1];
  logic                         comp  [MAX_SIDE_LOG2+1:1];

  assign chain[MAX_SIDE_LOG2+1] = '0;
  assign comp[MAX_SIDE_LOG2+1]  = 1'b0;

  always_comb begin
    eff_l = (side_r > qbmp_pkg::LEVEL_W'(MAX_SIDE_LOG2)) ?
            qbmp_pkg::LEVEL_W'(MAX_SIDE_LOG2) : side_r;
    for (int j = 0; j < IDX_W; j++) begin
      idx_mask[j] = (j < 2 * int'(eff_l));
    end
    next_idx = (idx_r + IDX_W'(1)) & idx_mask;
    for (int m = 0; m < MAX_SIDE_LOG2; m++) begin
      off_x[m] = idx_r[2*m] ^ idx_r[2*m+1];
      off_y[m] = idx_r[2*m+1];
    end
    busy = 1'b0;
    for (int s = 1; s <= MAX_SIDE_LOG2; s++) begin
      busy = busy | chain[s].valid;
    end
  end

  assign adv          = !out_r.valid || out_ch.ready;
  assign in_ch.ready  = adv && !busy;
  assign accept       = in_ch.valid && in_ch.ready;
  assign clear        = cfg_we && (cfg_index == qbmp_pkg::CFG_SIDE_LOG2);
  assign ctl.clear    = clear;
  assign ctl.load     = accept;
  assign ctl.shift    = adv && !accept;

  genvar s;
  generate
    for (s = 1; s <= MAX_SIDE_LOG2; s++) begin : g_cell
      qbmp_cell #(
        .SPAN          (s),
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pixel     (in_ch.pixel),
        .side_log2 (eff_l),
        .next_idx  (next_idx),
        .off_x     (off_x),
        .off_y     (off_y),
        .base_x    (base_x_r),
        .base_y    (base_y_r),
        .comp_up   (comp[s+1]),
        .comp      (comp[s]),
        .node_in   (chain[s+1]),
        .node_out  (chain[s])
      );
    end
  endgenerate

  always_comb begin
    leaf.valid    = 1'b1;
    leaf.level    = eff_l;
    leaf.corner_x = qbmp_pkg::COORD_W'(base_x_r) + qbmp_pkg::COORD_W'(off_x);
    leaf.corner_y = qbmp_pkg::COORD_W'(base_y_r) + qbmp_pkg::COORD_W'(off_y);
    leaf.mean     = in_ch.pixel;
    leaf.last     = !comp[1];

    out_nxt = out_r;
    if (accept) begin
      out_nxt = leaf;
    end else if (adv) begin
      out_nxt = chain[1];
    end

    idx_nxt = idx_r;
    if (clear) begin
      idx_nxt = '0;
    end else if (accept) begin
      idx_nxt = next_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= qbmp_pkg::SIDE_LOG2_RESET;
      base_x_r <= '0;
      base_y_r <= '0;
      idx_r    <= '0;
      out_r    <= '0;
    end else begin
      idx_r <= idx_nxt;
      out_r <= out_nxt;
      if (cfg_we) begin
        case (cfg_index)
          qbmp_pkg::CFG_SIDE_LOG2: side_r   <= cfg_data[qbmp_pkg::LEVEL_W-1:0];
          qbmp_pkg::CFG_BASE_X:    base_x_r <= cfg_data[qbmp_pkg::BASE_W-1:0];
          qbmp_pkg::CFG_BASE_Y:    base_y_r <= cfg_data[qbmp_pkg::BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid    = out_r.valid;
  assign out_ch.level    = out_r.level;
  assign out_ch.corner_x = out_r.corner_x;
  assign out_ch.corner_y = out_r.corner_y;
  assign out_ch.mean     = out_r.mean;
  assign out_ch.last     = out_r.last;

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;

  localparam int MAX_SIDE    = 10;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [qbmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [qbmp_pkg::LEVEL_W-1:0] level;
    logic [qbmp_pkg::COORD_W-1:0] corner_x;
    logic [qbmp_pkg::COORD_W-1:0] corner_y;
    logic [qbmp_pkg::MEAN_W-1:0]  mean;
    logic                         last;
  } block_mean_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [qbmp_pkg::CFG_IDX_W-1:0] idx;
    logic [qbmp_pkg::CFG_W-1:0]     data;
    logic [qbmp_pkg::PIX_W-1:0]     pix;
    logic                           typed;
    block_mean_t                    want;
  } row_t;

  localparam int NROWS = 34;

  row_t plan [0:NROWS-1] = '{
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b1, '{4'd10, 13'd0, 13'd0, 8'd255, 1'b1}},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd0,   1'b1, '{4'd10, 13'd1, 13'd0, 8'd0, 1'b1}},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd17,  1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd200, 1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_SIDE_LOG2, 12'hFF0, 8'd0, 1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_X,    12'd4095, 8'd0, 1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_Y,    12'd4095, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd0,   1'b1, '{4'd0, 13'd4095, 13'd4095, 8'd0, 1'b1}},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b1, '{4'd0, 13'd4095, 13'd4095, 8'd255, 1'b1}},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_X,    12'd0, 8'd0,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_Y,    12'd0, 8'd0,   1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd128, 1'b1, '{4'd0, 13'd0, 13'd0, 8'd128, 1'b1}},
    '{ROW_REG,   qbmp_pkg::CFG_SIDE_LOG2, 12'd1, 8'd0,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_X,    12'd4095, 8'd0, 1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_Y,    12'd4095, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_REG,   CFG_UNUSED,              12'hABC, 8'd0, 1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_SIDE_LOG2, 12'd2, 8'd0,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_X,    12'd5, 8'd0,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_Y,    12'd7, 8'd0,   1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd0,   1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd1,   1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd2,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_BASE_X,    12'd100, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd3,   1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd4,   1'b0, '0},
    '{ROW_REG,   qbmp_pkg::CFG_SIDE_LOG2, 12'd15, 8'd0,  1'b0, '0},
    '{ROW_PIXEL, qbmp_pkg::CFG_SIDE_LOG2, 12'd0, 8'd77,  1'b1, '{4'd10, 13'd100, 13'd7, 8'd77, 1'b1}}
  };

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [qbmp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qbmp_pkg::CFG_W-1:0]     cfg_data;

  qbmp_in_if  pix_ch ();
  qbmp_out_if mean_ch ();

  quadtree_block_mean_pyramid #(
    .MAX_SIDE_LOG2(MAX_SIDE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_ch),
    .out_ch   (mean_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // pyramid state as the block should hold it
  logic [27:0]                   lvl_sum [0:MAX_SIDE];
  logic [19:0]                   pix_pos;
  logic [3:0]                    side_reg;
  logic [qbmp_pkg::BASE_W-1:0]   base_x_reg;
  logic [qbmp_pkg::BASE_W-1:0]   base_y_reg;

  block_mean_t pending_means [$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_requests;
  int stall_served;
  int stall_left;
  int n_fail;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic predict_pixel(input logic [7:0] p);
    int          L, mask, idx, nxt, offx, offy, span, cmask;
    block_mean_t nd;
    L = (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
    mask = (L == 0) ? 0 : (1 << (2 * L)) - 1;
    idx = int'(pix_pos) & mask;
    offx = 0;
    offy = 0;
    for (int m = 1; m <= L; m++) begin
      int sh, d;
      sh = L - m;
      d = (idx >> (2 * sh)) & 3;
      if (d == 1 || d == 2) offx |= 1 << sh;
      if (d >= 2) offy |= 1 << sh;
    end
    for (int m = 0; m < L; m++) lvl_sum[m] = lvl_sum[m] + 28'(p);
    nxt = (idx + 1) & mask;
    nd.level = 4'(L);
    nd.corner_x = 13'(int'(base_x_reg) + offx);
    nd.corner_y = 13'(int'(base_y_reg) + offy);
    nd.mean = p;
    nd.last = (L == 0 || (nxt & 3) != 0);
    pending_means.push_back(nd);
    for (int l = L - 1; l >= 0; l--) begin
      span = L - l;
      if ((nxt & ((1 << (2 * span)) - 1)) != 0) break;
      cmask = ~((1 << span) - 1);
      nd.level = 4'(l);
      nd.corner_x = 13'(int'(base_x_reg) + (offx & cmask));
      nd.corner_y = 13'(int'(base_y_reg) + (offy & cmask));
      nd.mean = 8'(lvl_sum[l] >> (2 * span));
      nd.last = !(l > 0 && (nxt & ((1 << (2 * span + 2)) - 1)) == 0);
      pending_means.push_back(nd);
      lvl_sum[l] = '0;
    end
    pix_pos = 20'(nxt);
  endtask

  task automatic send_pixel(input logic [7:0] p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    do @(posedge clk); while (!pix_ch.ready);
    predict_pixel(p);
  endtask

  task automatic drain_means();
    pix_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qbmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qbmp_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      qbmp_pkg::CFG_SIDE_LOG2: begin
        side_reg = data[3:0];
        pix_pos = '0;
        foreach (lvl_sum[m]) lvl_sum[m] = '0;
      end
      qbmp_pkg::CFG_BASE_X: base_x_reg = data;
      qbmp_pkg::CFG_BASE_Y: base_y_reg = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [qbmp_pkg::CFG_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 12'd4095;
    return 12'($urandom_range(0, 4095));
  endfunction

  // result channel: random backpressure, plus long hold-offs on request
  initial begin
    mean_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        mean_ch.ready <= 1'b0;
      end else if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = HOLD_CYCLES;
        mean_ch.ready <= 1'b0;
      end else begin
        mean_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_means
    block_mean_t want;
    if (rst_n && mean_ch.valid && mean_ch.ready) begin
      if (pending_means.size() == 0) begin
        n_fail++;
        $error("unexpected item: level %0d corner (%0d,%0d) mean %0d", mean_ch.level,
               mean_ch.corner_x, mean_ch.corner_y, mean_ch.mean);
      end else begin
        want = pending_means.pop_front();
        if (mean_ch.level !== want.level) begin
          n_fail++;
          $error("level: expected %0d, got %0d", want.level, mean_ch.level);
        end
        if (mean_ch.corner_x !== want.corner_x) begin
          n_fail++;
          $error("corner_x: expected %0d, got %0d", want.corner_x, mean_ch.corner_x);
        end
        if (mean_ch.corner_y !== want.corner_y) begin
          n_fail++;
          $error("corner_y: expected %0d, got %0d", want.corner_y, mean_ch.corner_y);
        end
        if (mean_ch.mean !== want.mean) begin
          n_fail++;
          $error("mean: expected %0d, got %0d", want.mean, mean_ch.mean);
        end
        if (mean_ch.last !== want.last) begin
          n_fail++;
          $error("last: expected %0d, got %0d", want.last, mean_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (mean_ch.valid && mean_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          r, side, count, cut, sent, regions;
    logic [7:0]  p;
    rst_n          <= 1'b0;
    pix_ch.valid   <= 1'b0;
    pix_ch.pixel   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    stall_requests = 0;
    send_idle_pct  = 18;
    recv_idle_pct  = 45;
    side_reg       = qbmp_pkg::SIDE_LOG2_RESET;
    base_x_reg     = '0;
    base_y_reg     = '0;
    pix_pos        = '0;
    foreach (lvl_sum[m]) lvl_sum[m] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_means();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].pix);
        if (plan[i].typed) begin
          void'(pending_means.pop_back());
          pending_means.push_back(plan[i].want);
        end
      end
    end

    regions = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 18 : 0;
      sent = 0;
      while (sent < 100) begin
        r = $urandom_range(0, 99);
        side = (r < 15) ? 0 : (r < 50) ? 1 : (r < 75) ? 2 : (r < 88) ? 3 :
               (r < 94) ? 4 : $urandom_range(10, 15);
        if (regions == 0) side = 3;
        count = (side <= 3) ? (1 << (2 * side)) :
                (side == 4) ? $urandom_range(16, 48) : $urandom_range(1, 6);
        // broken region: cut short, the next side write restarts it
        if (side >= 1 && side <= 3 && $urandom_range(0, 9) == 0)
          count = $urandom_range(1, count - 1);
        cut = (side >= 2 && count > 1 && $urandom_range(0, 3) == 0) ?
              $urandom_range(1, count - 1) : -1;
        drain_means();
        write_reg(qbmp_pkg::CFG_SIDE_LOG2, {8'($urandom_range(0, 255)), 4'(side)});
        if ($urandom_range(0, 1) == 1) begin
          write_reg(qbmp_pkg::CFG_BASE_X, pick_base());
          write_reg(qbmp_pkg::CFG_BASE_Y, pick_base());
        end
        if (regions == 0) stall_requests++;
        for (int i = 0; i < count; i++) begin
          if (i == cut) begin
            drain_means();
            write_reg(($urandom_range(0, 1) == 1) ? qbmp_pkg::CFG_BASE_X : qbmp_pkg::CFG_BASE_Y,
                      pick_base());
          end
          r = $urandom_range(0, 99);
          p = (r < 12) ? 8'd0 : (r < 24) ? 8'd255 : 8'($urandom_range(0, 255));
          send_pixel(p);
        end
        sent += count;
        regions++;
      end
    end

    pix_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_means.size() != 0) begin
      $error("%0d expected items never arrived", pending_means.size());
    end
    if (n_fail == 0 && pending_means.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
